// ----- design/crlf_pkg.sv -----
package crlf_pkg;

  // Register indexes of the configuration port.
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_WAYS   = 1'b1;

  // Replacement policy codes.
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic       POLICY_RESET = POLICY_LRU;
  localparam logic [3:0] WAYS_RESET   = 4'd8;

  // Per-cell control for one update of the age-order chain.
  typedef struct packed {
    logic shift; // take the neighbor's entry
    logic load;  // take the broadcast entry
  } cell_ctl_t;

endpackage

// ----- design/crlf_cell.sv -----
module crlf_cell #(
  parameter int SW = 3,
  parameter int BW = 16
) (
  input  logic                clk,
  input  crlf_pkg::cell_ctl_t ctl,
  input  logic [SW-1:0]       next_id,
  input  logic [BW-1:0]       next_block,
  input  logic [SW-1:0]       load_id,
  input  logic [BW-1:0]       load_block,
  input  logic [BW-1:0]       key,
  output logic [SW-1:0]       id,
  output logic [BW-1:0]       block,
  output logic                match
);
  import crlf_pkg::*;

  // One position of the age order: which slot sits here and the block it holds.
  always_ff @(posedge clk) begin
    priority if (ctl.load) begin
      id    <= load_id;
      block <= load_block;
    end else if (ctl.shift) begin
      id    <= next_id;
      block <= next_block;
    end
  end

  assign match = (block == key);

endmodule

// ----- design/cache_replacement_lru_fifo.sv -----
// Fully associative cache directory with FIFO or LRU replacement. Each input
// transaction carries one block reference; each produces exactly one result
// transaction with hit, the slot now holding the block, whether a resident
// block was evicted (and which), and the saturating hit total after this
// reference. The age order lives in a row of cells, oldest at cell 0; every
// cell compares its block with the reference at once, and an update moves the
// chosen entry to the newest end while the cells behind it each take their
// neighbor's entry. A reference is first captured in IDLE; LOOKUP then does
// the compare across the cells and the chain update, which writes the output
// register. The next reference is accepted as soon as that update is done,
// even while the previous result is still waiting to be taken; a result that
// is stalled holds the lookup of the following reference until it leaves.
// Configuration (policy at address 0, ways_in_use at 4) is written over the
// APB-style port by the user only while idle; the block does not enforce it.
// A ways_in_use of 0 acts as 1, above WAYS as WAYS; lowering it frees no slot.
module cache_replacement_lru_fifo #(
  parameter int WAYS       = 8,
  parameter int BLOCK_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Reference channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] block_address,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [2:0]  slot,
  output logic        evicted,
  output logic [15:0] evicted_block,
  output logic [15:0] hit_total
);
  import crlf_pkg::*;

  // Slot id and age position width; the stored block uses only the bits that
  // both the port and BLOCK_BITS keep.
  localparam int SW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int BW = (BLOCK_BITS < 16) ? BLOCK_BITS : 16;
  localparam int FW = $clog2(WAYS + 1);
  localparam int CW = (FW > 4) ? FW : 4;
  localparam logic [CW-1:0] WAYS_C = CW'(WAYS);

  typedef enum logic {
    IDLE,
    LOOKUP
  } state_t;

  state_t      state;
  logic        policy;
  logic [3:0]  ways_in_use;
  logic [FW-1:0] fill_count;
  logic [15:0] hit_counter;
  logic [BW-1:0] key;

  // Configuration registers. pready is always high, so the access phase
  // completes the write.
  logic cfg_write;
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy      <= POLICY_RESET;
      ways_in_use <= WAYS_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_POLICY: policy      <= pwdata[0];
        REG_WAYS:   ways_in_use <= pwdata[3:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_POLICY: prdata = {31'd0, policy};
      REG_WAYS:   prdata = {28'd0, ways_in_use};
      default:    prdata = '0;
    endcase
  end

  // Cell row.
  cell_ctl_t     ctl     [WAYS];
  logic [SW-1:0] cell_id [WAYS];
  logic [BW-1:0] cell_blk[WAYS];
  logic [SW-1:0] nb_id   [WAYS];
  logic [BW-1:0] nb_blk  [WAYS];
  logic [WAYS-1:0] match;
  logic [SW-1:0] load_id;
  logic [BW-1:0] load_blk;

  for (genvar i = 0; i < WAYS; i++) begin : g_cell
    if (i < WAYS - 1) begin : g_mid
      assign nb_id[i]  = cell_id[i+1];
      assign nb_blk[i] = cell_blk[i+1];
    end else begin : g_last
      assign nb_id[i]  = cell_id[i];
      assign nb_blk[i] = cell_blk[i];
    end

    crlf_cell #(
      .SW(SW),
      .BW(BW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .next_id   (nb_id[i]),
      .next_block(nb_blk[i]),
      .load_id   (load_id),
      .load_block(load_blk),
      .key       (key),
      .id        (cell_id[i]),
      .block     (cell_blk[i]),
      .match     (match[i])
    );
  end

  // Lookup: only filled cells take part. Blocks in the filled cells are
  // distinct, so at most one cell matches.
  logic [WAYS-1:0] hit_vec;
  logic [SW-1:0]   hit_pos;
  logic [SW-1:0]   hit_id;
  logic            found;
  logic [CW-1:0]   fill_ext;
  logic [CW-1:0]   eff_ways;
  logic            has_room;
  logic            do_move;
  logic            do_append;
  logic [SW-1:0]   move_pos;
  logic [FW-1:0]   last_pos;
  logic            advance;

  assign fill_ext = CW'(fill_count);

  always_comb begin
    priority if (ways_in_use == 4'd0) begin
      eff_ways = CW'(1);
    end else if (CW'(ways_in_use) > WAYS_C) begin
      eff_ways = WAYS_C;
    end else begin
      eff_ways = CW'(ways_in_use);
    end
  end

  assign has_room = (fill_ext < eff_ways);
  assign last_pos = fill_count - FW'(1);

  always_comb begin
    hit_pos = '0;
    hit_id  = '0;
    for (int i = 0; i < WAYS; i++) begin
      hit_vec[i] = match[i] && (FW'(i) < fill_count);
      if (hit_vec[i]) begin
        hit_pos = hit_pos | SW'(i);
        hit_id  = hit_id | cell_id[i];
      end
    end
  end

  assign found   = |hit_vec;
  assign advance = (state == LOOKUP) && (!out_valid || !out_stall);

  // A hit under LRU moves the matching entry to the newest end; a miss with
  // the directory full evicts the oldest entry and moves it the same way
  // carrying the new block; a miss with room appends a fresh slot.
  assign do_move   = advance && ((found && policy == POLICY_LRU) || (!found && !has_room));
  assign do_append = advance && !found && has_room;
  assign move_pos  = found ? hit_pos : '0;

  always_comb begin
    if (do_append) begin
      load_id  = SW'(fill_count);
      load_blk = key;
    end else if (found) begin
      load_id  = hit_id;
      load_blk = key;
    end else begin
      load_id  = cell_id[0];
      load_blk = key;
    end
  end

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      ctl[i].shift = do_move && (FW'(i) >= FW'(move_pos)) && (FW'(i) < last_pos);
      ctl[i].load  = (do_move && (FW'(i) == last_pos))
                  || (do_append && (FW'(i) == fill_count));
    end
  end

  // Control, counters and the output register.
  logic [15:0] hit_counter_next;
  assign hit_counter_next = (found && hit_counter != 16'hFFFF) ? hit_counter + 16'd1
                                                               : hit_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      out_valid   <= 1'b0;
      fill_count  <= '0;
      hit_counter <= '0;
    end else begin
      // A new result takes the output register; otherwise a taken result
      // leaves it empty.
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            key   <= block_address[BW-1:0];
            state <= LOOKUP;
          end
        end
        LOOKUP: begin
          if (advance) begin
            hit           <= found;
            hit_total     <= hit_counter_next;
            hit_counter   <= hit_counter_next;
            evicted       <= !found && !has_room;
            evicted_block <= (!found && !has_room) ? 16'(cell_blk[0]) : 16'd0;
            if (found) begin
              slot <= 3'(hit_id);
            end else if (has_room) begin
              slot       <= 3'(fill_count);
              fill_count <= fill_count + FW'(1);
            end else begin
              slot <= 3'(cell_id[0]);
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign in_stall = (state != IDLE);

endmodule
